// ----- design/hpq_pkg.sv -----
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; imported by every module of the block.
package hpq_pkg;

	// Field widths of the stream items.
	localparam int VAL_W = 31;
	localparam int ST_W = 2;

	// Default number of heap entries.
	localparam int DEPTH_DEF = 1024;

	// Command codes carried in the input tuser.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP = 1'b1;

	// Status codes carried in the output tuser.
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	// One result item handed from the sequencer to the output register.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ST_W-1:0] status;
	} res_t;

endpackage

// ----- design/hpq_ram.sv -----
// Heap storage: one write port, two read ports, registered read data.
// Depends on hpq_pkg for the value width.
module hpq_ram
	import hpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [VAL_W-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr_a,
	input logic [AW-1:0] raddr_b,
	output logic [VAL_W-1:0] rdata_a,
	output logic [VAL_W-1:0] rdata_b
);

	logic [VAL_W-1:0] mem [DEPTH];

	// Write port and both read ports; read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- design/hpq_seq.sv -----
// Sequencer of the heap: takes one command at a time and walks the heap
// level by level through hpq_ram. Depends on hpq_pkg and hpq_ram.
module hpq_seq
	import hpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_cmd,
	input logic [VAL_W-1:0] in_value,
	input logic slot_free,
	output logic res_valid,
	output res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = AW + 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ERR = 3'd1;
	localparam logic [2:0] S_POP_EMIT = 3'd2;
	localparam logic [2:0] S_DN_RD = 3'd3;
	localparam logic [2:0] S_DN_CMP = 3'd4;
	localparam logic [2:0] S_UP_RD = 3'd5;
	localparam logic [2:0] S_UP_CMP = 3'd6;

	logic [2:0] state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [ST_W-1:0] err_q, err_d;
	logic rok_q, rok_d;

	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [VAL_W-1:0] mem_wdata, rd_a, rd_b;

	logic accept;
	logic [CW-1:0] cnt_m1;
	logic [XW-1:0] cnt_x, lc_x, rc_x;
	logic [AW-1:0] pos_m1, parent;
	logic take_r;
	logic [VAL_W-1:0] big_val;

	hpq_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// Index arithmetic for the current position.
	assign accept = in_valid && in_ready;
	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_x = {{(XW - CW){1'b0}}, cnt_q};
	assign lc_x = {1'b0, pos_q, 1'b1};
	assign rc_x = lc_x + XW'(1);
	assign pos_m1 = pos_q - AW'(1);
	assign parent = pos_m1 >> 1;
	assign take_r = rok_q && (rd_b > rd_a);
	assign big_val = take_r ? rd_b : rd_a;
	assign in_ready = (state_q == S_IDLE);

	// Next-state logic, memory requests and result issue.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pos_d = pos_q;
		val_d = val_q;
		err_d = err_q;
		rok_d = rok_q;
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = val_q;
		mem_re = 1'b0;
		mem_raddr_a = '0;
		mem_raddr_b = cnt_m1[AW-1:0];
		res_valid = 1'b0;
		res.value = '0;
		res.status = err_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_PUSH) begin
						if (cnt_q >= CW'(DEPTH)) begin
							err_d = ST_FULL;
							state_d = S_ERR;
						end else begin
							pos_d = cnt_q[AW-1:0];
							val_d = in_value;
							cnt_d = cnt_q + CW'(1);
							state_d = S_UP_RD;
						end
					end else if (cnt_q == '0) begin
						err_d = ST_EMPTY;
						state_d = S_ERR;
					end else begin
						// Fetch the root and the last entry together.
						mem_re = 1'b1;
						cnt_d = cnt_m1;
						state_d = S_POP_EMIT;
					end
				end
			end
			S_ERR: begin
				if (slot_free) begin
					res_valid = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP_EMIT: begin
				if (slot_free) begin
					res_valid = 1'b1;
					res.value = rd_a;
					res.status = ST_OK;
					val_d = rd_b;
					pos_d = '0;
					state_d = (cnt_q == '0) ? S_IDLE : S_DN_RD;
				end
			end
			S_DN_RD: begin
				if (lc_x >= cnt_x) begin
					mem_we = 1'b1;
					state_d = S_IDLE;
				end else begin
					mem_re = 1'b1;
					mem_raddr_a = lc_x[AW-1:0];
					mem_raddr_b = rc_x[AW-1:0];
					rok_d = (rc_x < cnt_x);
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (big_val <= val_q) begin
					state_d = S_IDLE;
				end else begin
					// Larger child moves up into the hole.
					mem_wdata = big_val;
					pos_d = take_r ? rc_x[AW-1:0] : lc_x[AW-1:0];
					state_d = S_DN_RD;
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
					state_d = S_IDLE;
				end else begin
					mem_re = 1'b1;
					mem_raddr_a = parent;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (rd_a >= val_q) begin
					state_d = S_IDLE;
				end else begin
					// Parent moves down into the hole.
					mem_wdata = rd_a;
					pos_d = parent;
					state_d = S_UP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// Working registers of the current command.
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		err_q <= err_d;
		rok_q <= rok_d;
	end

endmodule

// ----- design/max_heap_priority_queue_unit.sv -----
// Top level of the binary max-heap priority queue: stream ports, output register.
// Depends on hpq_pkg and hpq_seq.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser = cmd, tdata = value (bits 30:0)
//  m_axis    out        tdata = max_value (bits 30:0), tuser = status
//
// One command is in work at a time. Each level climbed or descended costs one heap
// memory read and one compare-and-write. A push ends with a write at the root or after
// a compare; a pop emits the root, then sinks the moved entry to a leaf or to its place,
// and a pop that empties the heap ends at the emit; an error only emits its status.
// Reset empties the heap at once. A full output register stalls a result until m_axis
// takes it; pushes that give no result are not.
module max_heap_priority_queue_unit
	import hpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata,  // [30:0] value, [31] zero fill
	input logic s_axis_tuser,         // [0] cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [30:0] max_value, [31] zero fill
	output logic [ST_W-1:0] m_axis_tuser // [1:0] status
);

	logic slot_free;
	logic res_valid;
	res_t res;
	logic out_valid_q;
	res_t out_res_q;

	assign slot_free = !out_valid_q || m_axis_tready;

	hpq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser),
		.in_value(s_axis_tdata[VAL_W-1:0]),
		.slot_free(slot_free),
		.res_valid(res_valid),
		.res(res)
	);

	// Output register: loads a result, clears after its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_res_q.value};
	assign m_axis_tuser = out_res_q.status;

	// A result is only issued when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> slot_free)
		else $error("result issued into a full output register");

	// No result is issued while the sequencer is waiting for a command.
	assert property (@(posedge clk) disable iff (!arst_n) s_axis_tready |-> !res_valid)
		else $error("result issued while idle");

	// Every accepted command leaves the sequencer busy in the cycle after its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("sequencer ready right after a transfer");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the max-heap priority queue: a shadow heap predicts every
// pop and every dropped push. Depends only on hpq_pkg and max_heap_priority_queue_unit.
module tb;
	import hpq_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 2 * 10 + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tuser = CMD_PUSH;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [ST_W-1:0] m_axis_tuser;

	// Shadow copy of the heap; it queues the result each accepted command should give.
	class heap_shadow;
		logic [VAL_W-1:0] slots [DEPTH_DEF];
		int unsigned fill = 0;
		res_t expected_results[$];
		int unsigned errors = 0;

		function void apply_cmd(logic cmd, logic [VAL_W-1:0] val);
			res_t r;
			int unsigned pos;
			int unsigned parent;
			int unsigned kid;
			logic [VAL_W-1:0] moving;
			if (cmd == CMD_PUSH) begin
				if (fill >= DEPTH_DEF) begin
					r.value = '0;
					r.status = ST_FULL;
					expected_results.push_back(r);
					return;
				end
				// Climb while strictly larger than the parent.
				pos = fill;
				fill++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (slots[parent] >= val)
						break;
					slots[pos] = slots[parent];
					pos = parent;
				end
				slots[pos] = val;
			end else if (fill == 0) begin
				r.value = '0;
				r.status = ST_EMPTY;
				expected_results.push_back(r);
			end else begin
				r.value = slots[0];
				r.status = ST_OK;
				expected_results.push_back(r);
				fill--;
				// The last entry takes the root and sinks below any strictly larger child.
				if (fill > 0) begin
					moving = slots[fill];
					pos = 0;
					forever begin
						kid = 2 * pos + 1;
						if (kid >= fill)
							break;
						if (kid + 1 < fill && slots[kid + 1] > slots[kid])
							kid++;
						if (slots[kid] <= moving)
							break;
						slots[pos] = slots[kid];
						pos = kid;
					end
					slots[pos] = moving;
				end
			end
		endfunction

		function void compare_result(logic [VAL_W-1:0] got_value, logic [ST_W-1:0] got_status);
			res_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual value %0d status %0d",
					$time, got_value, got_status);
				return;
			end
			want = expected_results.pop_front();
			if (got_value !== want.value) begin
				errors++;
				$display("%0t: max_value mismatch, expected %0d, actual %0d",
					$time, want.value, got_value);
			end
			if (got_status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got_status);
			end
		endfunction
	endclass

	heap_shadow mirror = new();
	bit quiet = 1'b0;
	int unsigned cycles = 0;

	max_heap_priority_queue_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	// Values lean on small numbers (ties) and the range ends as well as full-width noise.
	function automatic logic [VAL_W-1:0] draw_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = VAL_W'($urandom_range(0, 7));
			1: v = VAL_W'($urandom());
			2: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = {VAL_W{1'b1}};
					2: v = VAL_W'(1);
					default: v = {{(VAL_W - 1){1'b1}}, 1'b0};
				endcase
			end
			default: v = VAL_W'($urandom_range(0, 1000));
		endcase
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_cmd(input logic cmd, input logic [VAL_W-1:0] val);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, val};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		mirror.apply_cmd(cmd, val);
		@(negedge clk);
	endtask

	task automatic send_random(input int count, input int pop_pct);
		repeat (count) begin
			if ($urandom_range(0, 49) == 0)
				quiet = ~quiet;
			send_cmd(($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_PUSH, draw_value());
		end
	endtask

	// Hold off the sender until every pending result has been taken.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (mirror.expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result sink with random back-pressure.
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			mirror.compare_result(m_axis_tdata[VAL_W-1:0], m_axis_tuser);
			@(negedge clk);
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty pop, range ends, zero, equal values, then drain past empty.
		send_cmd(CMD_POP, {VAL_W{1'b1}});
		send_cmd(CMD_PUSH, '0);
		send_cmd(CMD_PUSH, {VAL_W{1'b1}});
		send_cmd(CMD_PUSH, VAL_W'(1));
		send_cmd(CMD_PUSH, VAL_W'(32'h4000_0000));
		send_cmd(CMD_PUSH, VAL_W'(32'h2AAA_AAAA));
		send_cmd(CMD_PUSH, VAL_W'(32'h5555_5555));
		send_cmd(CMD_PUSH, VAL_W'(5));
		send_cmd(CMD_PUSH, VAL_W'(5));
		send_cmd(CMD_PUSH, VAL_W'(5));
		send_cmd(CMD_PUSH, '0);
		repeat (11)
			send_cmd(CMD_POP, '0);
		drain_results();

		// Mixed traffic around a small heap, empty pops included.
		send_random(100, 45);
		drain_results();

		// Fill to capacity, first without idling, then hammer the full heap.
		quiet = 1'b1;
		while (mirror.fill < DEPTH_DEF / 2)
			send_cmd(CMD_PUSH, draw_value());
		quiet = 1'b0;
		while (mirror.fill < DEPTH_DEF)
			send_cmd(CMD_PUSH, draw_value());
		repeat (6)
			send_cmd(CMD_PUSH, draw_value());
		drain_results();

		// Hover at the full boundary, then mostly pops from a deep heap.
		send_random(40, 50);
		send_random(60, 80);
		s_axis_tvalid <= 1'b0;

		while (mirror.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.expected_results.size() != 0) begin
			mirror.errors++;
			$display("%0t: %0d expected results never arrived",
				$time, mirror.expected_results.size());
		end
		if (mirror.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/hpq_pkg.sv
design/hpq_ram.sv
design/hpq_seq.sv
design/max_heap_priority_queue_unit.sv
verif/tb.sv
